/* src/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared widths, codes and types of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  // Field widths fixed by the page entry format
  localparam int FRAME_W  = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 13;

  // Largest frame count that new_frame can express
  localparam int FRAME_LIMIT = 4096;

  // Default geometry of the bitmap
  localparam int NUM_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // Request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NOP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_FRD,
    S_FWR,
    S_OUT
  } state_t;

  // Bitmap memory strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

endpackage

/* src/frame_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit physical frame allocator over a used-frame bitmap held in memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap to zero, one word per cycle, before
// in_ready first rises; cfg writes are taken throughout. One item is worked at
// a time. An allocation for an empty entry reads the bitmap one word per cycle
// through the single read port, scanning at most max(1, ceil(min(limit,
// NUM_FRAMES) / WORD_BITS)) words, and loads the result when it finds a free
// bit or reaches the last word. A free reads the frame's word, writes it back
// with the bit cleared, then loads the result. An allocation for an entry that
// already holds a frame, or a free of an empty entry or of a frame beyond the
// bitmap, goes straight to loading the result. The result sits in an output
// register, so the next item is accepted while it waits for out_ready; a second
// result stalls the input until the first is taken.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [FRAME_W-1:0]  entry_frame,
  input  logic                kernel_page,
  input  logic                writable_page,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FRAME_W-1:0]  new_frame,
  output logic [STATUS_W-1:0] status,
  output logic                present_bit,
  output logic                write_bit,
  output logic                user_bit
);

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAP       = (NUM_FRAMES < FRAME_LIMIT) ? NUM_FRAMES : FRAME_LIMIT;

  logic [CFG_W-1:0]     scan_limit;
  logic [CFG_W-1:0]     scan_limit_next;
  map_ctl_t             map_ctl;
  logic [ADDR_W-1:0]    map_raddr;
  logic [ADDR_W-1:0]    map_waddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic [WORD_BITS-1:0] map_rdata;

  // Saturate the frame count to what the bitmap and the frame field can hold
  assign scan_limit_next = (cfg_wdata > CFG_W'(CAP)) ? CFG_W'(CAP) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= CFG_W'(CAP);
    end else if (cfg_we) begin
      scan_limit <= scan_limit_next;
    end
  end

  fba_engine #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS),
    .MAP_WORDS  (MAP_WORDS),
    .ADDR_W     (ADDR_W)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .scan_limit    (scan_limit),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .entry_frame   (entry_frame),
    .kernel_page   (kernel_page),
    .writable_page (writable_page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_frame     (new_frame),
    .status        (status),
    .present_bit   (present_bit),
    .write_bit     (write_bit),
    .user_bit      (user_bit),
    .map_ctl       (map_ctl),
    .map_raddr     (map_raddr),
    .map_waddr     (map_waddr),
    .map_wdata     (map_wdata),
    .map_rdata     (map_rdata)
  );

  fba_map_ram #(
    .DEPTH  (MAP_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .ctl   (map_ctl),
    .raddr (map_raddr),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

endmodule

/* src/fba_map_ram.sv */
// ----------------------------------------------------------------------------
// fba_map_ram
// Used-frame bitmap store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fba_map_ram import fba_pkg::*; #(
  parameter int DEPTH  = NUM_FRAMES_DEF / WORD_BITS_DEF,
  parameter int WIDTH  = WORD_BITS_DEF,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  map_ctl_t          ctl,
  input  logic [ADDR_W-1:0] raddr,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fba_engine.sv */
// ----------------------------------------------------------------------------
// fba_engine
// Request sequencer: clears the bitmap after reset, scans it by word for the
// lowest free frame and sets its bit, clears a freed frame's bit, holds the result.
// ----------------------------------------------------------------------------
module fba_engine import fba_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int MAP_WORDS  = NUM_FRAMES_DEF / WORD_BITS_DEF,
  parameter int ADDR_W     = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_W-1:0]     scan_limit,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [FRAME_W-1:0]   entry_frame,
  input  logic                 kernel_page,
  input  logic                 writable_page,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAME_W-1:0]   new_frame,
  output logic [STATUS_W-1:0]  status,
  output logic                 present_bit,
  output logic                 write_bit,
  output logic                 user_bit,
  // bitmap memory
  output map_ctl_t             map_ctl,
  output logic [ADDR_W-1:0]    map_raddr,
  output logic [ADDR_W-1:0]    map_waddr,
  output logic [WORD_BITS-1:0] map_wdata,
  input  logic [WORD_BITS-1:0] map_rdata
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int BASE_W = CFG_W + 1;
  // frame / WORD_BITS as a multiply by a rounded-up reciprocal, exact for 12-bit frames
  localparam int DIV_SH = FRAME_W + BIT_W;
  localparam int DIV_M  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = 2 * FRAME_W + 2;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  state_t state, state_next;

  logic [ADDR_W-1:0]  clr_word;
  logic [ADDR_W-1:0]  chk_word;
  logic [BASE_W-1:0]  base;
  logic [FRAME_W-1:0] req_entry;
  logic               req_kern;
  logic               req_wr;
  logic [FRAME_W-1:0] fq;
  logic [BIT_W-1:0]   fbit;

  logic [FRAME_W-1:0] res_frame;
  status_t            res_status;
  logic               res_present;
  logic               res_write;
  logic               res_user;

  logic                 accept;
  logic                 entry_ok;
  logic [PROD_W-1:0]    quot_prod;
  logic [FRAME_W-1:0]   fq_base;
  logic [FRAME_W-1:0]   frame_rem;
  logic [BASE_W-1:0]    rem;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] free_bits;
  logic                 hit;
  logic [BIT_W-1:0]     hit_idx;
  logic [BASE_W-1:0]    hit_frame;
  logic                 last_word;
  logic                 out_load;

  assign accept   = in_valid && in_ready;
  assign entry_ok = (32'(entry_frame) < NUM_FRAMES);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Word index and bit of a frame to free
  assign quot_prod = PROD_W'(entry_frame) * PROD_W'(DIV_M);
  assign fq_base   = fq * FRAME_W'(WORD_BITS);
  assign frame_rem = req_entry - fq_base;

  // Free frames of the word under scan that lie below the limit
  assign rem       = BASE_W'(scan_limit) - base;
  assign last_word = (base + BASE_W'(WORD_BITS)) >= BASE_W'(scan_limit);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = (BASE_W'(b) < rem);
    end
  end

  assign free_bits = ~map_rdata & avail;
  assign hit       = |free_bits;

  // Lowest free bit wins
  always_comb begin
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_idx = BIT_W'(i);
      end
    end
  end

  assign hit_frame = base + BASE_W'(hit_idx);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    map_ctl    = '0;
    map_raddr  = chk_word + ADDR_W'(1);
    map_waddr  = chk_word;
    map_wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        map_ctl.wr_en = 1'b1;
        map_waddr     = clr_word;
        if (clr_word == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == MODE_ALLOC) begin
            if (entry_frame != '0) begin
              state_next = S_OUT;
            end else begin
              map_ctl.rd_en = 1'b1;
              map_raddr     = '0;
              state_next    = S_CHK;
            end
          end else if ((entry_frame != '0) && entry_ok) begin
            state_next = S_FRD;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_CHK: begin
        // fetch the next word ahead; it is dropped on a hit or at the last word
        map_ctl.rd_en = 1'b1;
        if (hit) begin
          map_ctl.wr_en = 1'b1;
          map_wdata     = map_rdata | (WORD_BITS'(1) << hit_idx);
          state_next    = S_OUT;
        end else if (last_word) begin
          state_next = S_OUT;
        end
      end
      S_FRD: begin
        map_ctl.rd_en = 1'b1;
        map_raddr     = ADDR_W'(fq);
        state_next    = S_FWR;
      end
      S_FWR: begin
        map_ctl.wr_en = 1'b1;
        map_waddr     = ADDR_W'(fq);
        map_wdata     = map_rdata & ~(WORD_BITS'(1) << fbit);
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Clear sweep counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_word  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_word <= clr_word + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, scan and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_entry   <= entry_frame;
      req_kern    <= kernel_page;
      req_wr      <= writable_page;
      chk_word    <= '0;
      base        <= '0;
      fq          <= FRAME_W'(quot_prod >> DIV_SH);
      res_present <= 1'b0;
      res_write   <= 1'b0;
      res_user    <= 1'b0;
      if (mode == MODE_ALLOC) begin
        res_frame  <= entry_frame;
        res_status <= (entry_frame != '0) ? ST_NOP : ST_DONE;
      end else begin
        res_frame  <= '0;
        res_status <= (entry_frame == '0) ? ST_NOP : ST_DONE;
      end
    end
    if (state == S_CHK) begin
      if (hit) begin
        res_frame   <= hit_frame[FRAME_W-1:0];
        res_status  <= ST_DONE;
        res_present <= 1'b1;
        res_write   <= req_wr;
        res_user    <= ~req_kern;
      end else if (last_word) begin
        res_status <= ST_FULL;
      end else begin
        chk_word <= chk_word + ADDR_W'(1);
        base     <= base + BASE_W'(WORD_BITS);
      end
    end
    if (state == S_FRD) begin
      fbit <= frame_rem[BIT_W-1:0];
    end
    if (out_load) begin
      new_frame   <= res_frame;
      status      <= res_status;
      present_bit <= res_present;
      write_bit   <= res_write;
      user_bit    <= res_user;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item left the sequencer idle");

  a_scan_below_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> (base < BASE_W'(scan_limit)) || (base == '0))
    else $error("scan went past the frame limit");

  a_full_result_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> new_frame == '0 && !present_bit)
    else $error("full result carries a frame");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && present_bit |-> CFG_W'(new_frame) < scan_limit)
    else $error("allocated frame at or above the limit");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame bitmap allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free requests through the valid/ready request channel
// and compares every result against a cycle-free model of the used-frame
// bitmap. The sequence covers directed corner cases first, then random
// sequences over several frame counts, including 0 and the 13-bit maximum,
// a long result hold-off that fills the block, and a final run with no idling.
// ----------------------------------------------------------------------------
module tb;
  import fba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 6;
  localparam int END_WAIT    = 140;

  typedef struct packed {
    logic [FRAME_W-1:0] new_frame;
    status_t            status;
    logic               present;
    logic               writeable;
    logic               user;
  } frame_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                mode;
  logic [FRAME_W-1:0]  entry_frame;
  logic                kernel_page;
  logic                writable_page;
  logic                out_valid;
  logic                out_ready;
  logic [FRAME_W-1:0]  new_frame;
  logic [STATUS_W-1:0] status;
  logic                present_bit;
  logic                write_bit;
  logic                user_bit;

  // Model state: used-frame bitmap and the managed frame count
  bit               used_frames [NUM_FRAMES_DEF];
  logic [CFG_W-1:0] frame_count;
  frame_result_t    pending_results [$];
  logic [FRAME_W-1:0] held_frames [$];

  int  error_count   = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  full_reports  = 0;
  int  cycle_count   = 0;
  int  stall_request = 0;
  int  stall_left    = 0;
  bit  idle_enable   = 1'b1;

  frame_bitmap_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .entry_frame   (entry_frame),
    .kernel_page   (kernel_page),
    .writable_page (writable_page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_frame     (new_frame),
    .status        (status),
    .present_bit   (present_bit),
    .write_bit     (write_bit),
    .user_bit      (user_bit)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Compute the result of one request and update the bitmap
  function automatic frame_result_t frame_request_outcome(logic m, logic [FRAME_W-1:0] ef,
                                                         logic k, logic w);
    frame_result_t r;
    int unsigned   lim;
    r = '0;
    if (m == MODE_FREE) begin
      if (ef == '0) begin
        r.status = ST_NOP;
      end else begin
        used_frames[ef] = 1'b0;
        r.status = ST_DONE;
      end
      return r;
    end
    if (ef != '0) begin
      r.new_frame = ef;
      r.status    = ST_NOP;
      return r;
    end
    // Saturate the scan to the bitmap size and the range of new_frame
    lim = 32'(frame_count);
    if (lim > NUM_FRAMES_DEF) lim = NUM_FRAMES_DEF;
    if (lim > FRAME_LIMIT) lim = FRAME_LIMIT;
    r.status = ST_FULL;
    for (int f = 0; f < lim; f++) begin
      if (!used_frames[f]) begin
        used_frames[f] = 1'b1;
        r.new_frame = f[FRAME_W-1:0];
        r.status    = ST_DONE;
        r.present   = 1'b1;
        r.writeable = w;
        r.user      = !k;
        return r;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, logic [15:0] got);
    if (got !== 16'(want)) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(logic m, logic [FRAME_W-1:0] ef, logic k, logic w);
    frame_result_t r;
    int            idx [$];
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    entry_frame   <= ef;
    kernel_page   <= k;
    writable_page <= w;
    do @(posedge clk); while (!in_ready);
    r = frame_request_outcome(m, ef, k, w);
    pending_results.push_back(r);
    items_sent++;
    // Track frames that may later be freed; frame 0 cannot be freed by entry
    if (m == MODE_ALLOC && r.status == ST_DONE && r.new_frame != '0)
      held_frames.push_back(r.new_frame);
    if (m == MODE_FREE && r.status == ST_DONE) begin
      idx = held_frames.find_first_index(x) with (x == ef);
      if (idx.size() != 0) held_frames.delete(idx[0]);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_frame_count(logic [CFG_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    frame_count  = value;
  endtask

  // Random requests: mostly allocations and frees of held frames, some noise
  task automatic random_requests(int n);
    int unsigned pick;
    logic        k;
    logic        w;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      k    = 1'($urandom_range(0, 1));
      w    = 1'($urandom_range(0, 1));
      if (pick < 50 || (pick < 78 && held_frames.size() == 0))
        send_item(MODE_ALLOC, '0, k, w);
      else if (pick < 78)
        send_item(MODE_FREE, held_frames[$urandom_range(0, held_frames.size() - 1)], k, w);
      else if (pick < 86)
        send_item(MODE_ALLOC, FRAME_W'($urandom_range(1, 4095)), k, w);
      else if (pick < 90)
        send_item(MODE_FREE, '0, k, w);
      else
        send_item(MODE_FREE, FRAME_W'($urandom_range(0, 4095)), k, w);
    end
  endtask

  // Corner cases at the reset frame count, at small counts and at the register extremes
  task automatic test_directed();
    send_item(MODE_ALLOC, '0, 1'b0, 1'b0);
    send_item(MODE_ALLOC, '0, 1'b1, 1'b1);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b1);
    send_item(MODE_ALLOC, '0, 1'b1, 1'b0);
    send_item(MODE_ALLOC, 12'hFFF, 1'b0, 1'b1);
    send_item(MODE_ALLOC, 12'h001, 1'b1, 1'b0);
    send_item(MODE_FREE, '0, 1'b0, 1'b0);
    send_item(MODE_FREE, 12'd2, 1'b1, 1'b1);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b1);
    send_item(MODE_FREE, 12'hFFF, 1'b0, 1'b0);
    send_item(MODE_FREE, 12'hAAA, 1'b1, 1'b0);
    send_item(MODE_FREE, 12'h555, 1'b0, 1'b1);
    // Map full at a small count, then free and refill the top frame
    set_frame_count(13'd4);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b0);
    send_item(MODE_FREE, 12'd3, 1'b0, 1'b0);
    send_item(MODE_ALLOC, '0, 1'b1, 1'b1);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b1);
    // Free above the managed count still clears the bit
    set_frame_count(13'd2);
    send_item(MODE_FREE, 12'd3, 1'b1, 1'b0);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b0);
    set_frame_count(13'd0);
    send_item(MODE_ALLOC, '0, 1'b1, 1'b1);
    // Oversized count saturates to the bitmap size
    set_frame_count(13'h1FFF);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b1);
    send_item(MODE_ALLOC, '0, 1'b1, 1'b1);
    set_frame_count(13'd1);
    send_item(MODE_ALLOC, '0, 1'b0, 1'b0);
  endtask

  task automatic test_count_sweep();
    set_frame_count(13'd40);
    random_requests(90);
    set_frame_count(13'd4096);
    random_requests(90);
    set_frame_count(13'd1);
    random_requests(20);
    set_frame_count(13'd200);
    random_requests(90);
    set_frame_count(13'h1FFF);
    random_requests(40);
    set_frame_count(13'd0);
    random_requests(10);
    set_frame_count(13'd96);
    random_requests(50);
  endtask

  // Hold results off for a long stretch so the block stalls its input
  task automatic test_back_pressure();
    set_frame_count(13'd4096);
    stall_request = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2 && held_frames.size() != 0)
        send_item(MODE_FREE, held_frames[0], 1'b0, 1'b1);
      else
        send_item(MODE_ALLOC, '0, i[0], i[1]);
    end
  endtask

  task automatic test_streaming();
    idle_enable = 1'b0;
    set_frame_count(13'd64);
    random_requests(60);
  endtask

  // Result receiver: random hold-off bursts, plus the long requested hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_request != 0) begin
      stall_left     = stall_request - 1;
      stall_request  = 0;
      out_ready     <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: new_frame %0d status %0d",
               new_frame, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_FULL) full_reports++;
        check_field("new_frame", 32'(want.new_frame), 16'(new_frame));
        check_field("status", 32'(want.status), 16'(status));
        check_field("present_bit", 32'(want.present), 16'(present_bit));
        check_field("write_bit", 32'(want.writeable), 16'(write_bit));
        check_field("user_bit", 32'(want.user), 16'(user_bit));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    mode          <= MODE_ALLOC;
    entry_frame   <= '0;
    kernel_page   <= 1'b0;
    writable_page <= 1'b0;
    frame_count    = 13'd4096;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_count_sweep();
    test_back_pressure();
    test_streaming();

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d map-full reports).",
             items_sent, results_seen, full_reports);
    $display("Frame counts 0, 1, 2, 4, 40, 64, 96, 200, 4096 and 8191; long result hold-off.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
